// ----- src/sacl_pkg.sv -----
// Shared types, register codes and constants for the cache tag model.
package sacl_pkg;

	localparam int DEF_NUM_SETS = 256;
	localparam int DEF_NUM_WAYS = 8;

	localparam int ADDR_W = 32;
	localparam int TAG_W  = 32;
	localparam int CNT_W  = 32;

	// Configuration register indexes, taken from paddr[3:2].
	typedef enum logic [1:0] {
		REG_OFFSET_BITS = 2'd0,
		REG_INDEX_BITS  = 2'd1,
		REG_WAYS        = 2'd2,
		REG_WRITE_BACK  = 2'd3
	} reg_idx_t;

	localparam logic [4:0] RST_OFFSET_BITS = 5'd4;
	localparam logic [3:0] RST_INDEX_BITS  = 4'd0;
	localparam logic [3:0] RST_WAYS        = 4'd1;
	localparam logic       RST_WRITE_BACK  = 1'b1;

	// Access sequencer states.
	typedef enum logic {
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	// Configuration as seen by the datapath.
	typedef struct packed {
		logic [4:0] offset_bits;
		logic [3:0] index_bits;
		logic [3:0] ways_in_use;
		logic       write_back;
	} cfg_t;

	// Per-access flags from the lookup logic.
	typedef struct packed {
		logic hit;
		logic fetched;
		logic memw;
	} acc_flags_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction

endpackage

// ----- src/set_assoc_cache_lru_simulator_core.sv -----
// Top level of the set-associative LRU cache tag model.
//
// Usage: raise start with action (0 read, 1 write) and address while busy is
// low; the access is taken at that clock edge. The set row is read from the
// set memory in the next cycle, looked up and written back at the edge that
// ends it. The result (hit, fetched_block, wrote_memory and the four
// saturating totals) appears with done high for exactly one cycle after that.
// busy is high for one cycle, so a new access can be taken in the cycle that
// done shows. The set memory read is registered, and the modified row is
// written back before the next access reads it.
// The receiver cannot stall; flags and totals hold until the next result.
// Configuration goes through the APB port (offset_bits at 0x0, index_bits at
// 0x4, ways_in_use at 0x8, write_back at 0xC) while no access is in flight.
// Reset clears the counters and restores the register defaults; every set
// reads as empty with ages equal to way numbers until it is first written,
// so no clearing pass is needed.
module set_assoc_cache_lru_simulator_core import sacl_pkg::*; #(
	parameter int NUM_SETS = DEF_NUM_SETS,
	parameter int NUM_WAYS = DEF_NUM_WAYS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              action,
	input  logic [ADDR_W-1:0] address,
	output logic              done,
	output logic              hit,
	output logic              fetched_block,
	output logic              wrote_memory,
	output logic [CNT_W-1:0]  hit_total,
	output logic [CNT_W-1:0]  miss_total,
	output logic [CNT_W-1:0]  fetch_total,
	output logic [CNT_W-1:0]  memwrite_total,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int SW      = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int AW      = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int NW_W    = $clog2(NUM_WAYS + 1);
	localparam int LINE_W  = TAG_W + 2 + AW;
	localparam int ROW_W   = NUM_WAYS * LINE_W;
	localparam int SET_LOG = $clog2(NUM_SETS + 1) - 1;

	cfg_t             cfg;
	state_t           state_q, state_d;
	logic             accept, in_lookup;
	logic [3:0]       ib;
	logic [NW_W-1:0]  nw;
	logic [ADDR_W-1:0] blk;
	logic [SW-1:0]    set_idx, set_s1;
	logic [TAG_W-1:0] tag_s1;
	logic             wr_s1;
	logic [ROW_W-1:0] rd_row, new_row;
	acc_flags_t       flags;
	logic             done_q, hit_q, fetch_q, memw_q;
	logic [CNT_W-1:0] hit_cnt_q, miss_cnt_q, fetch_cnt_q, memw_cnt_q;

	assign pready = 1'b1;

	sacl_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	// Effective index bits and ways.
	always_comb begin
		ib = (cfg.index_bits > 4'(SET_LOG)) ? 4'(SET_LOG) : cfg.index_bits;
		if (cfg.ways_in_use == 4'd0) begin
			nw = NW_W'(1);
		end else if ({1'b0, cfg.ways_in_use} > 5'(NUM_WAYS)) begin
			nw = NW_W'(NUM_WAYS);
		end else begin
			nw = NW_W'(cfg.ways_in_use);
		end
	end

	// Address split into set and tag.
	assign blk     = address >> cfg.offset_bits;
	assign set_idx = SW'(blk & ~({ADDR_W{1'b1}} << ib));

	// Sequencer: next state.
	always_comb begin
		case (state_q)
			ST_IDLE:   state_d = start ? ST_LOOKUP : ST_IDLE;
			ST_LOOKUP: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer: outputs.
	always_comb begin
		case (state_q)
			ST_IDLE: begin
				busy      = 1'b0;
				in_lookup = 1'b0;
			end
			ST_LOOKUP: begin
				busy      = 1'b1;
				in_lookup = 1'b1;
			end
			default: begin
				busy      = 1'b0;
				in_lookup = 1'b0;
			end
		endcase
	end

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Access fields held for the lookup cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1 <= set_idx;
			tag_s1 <= blk >> ib;
			wr_s1  <= action;
		end
	end

	sacl_set_mem #(
		.NUM_SETS(NUM_SETS),
		.NUM_WAYS(NUM_WAYS)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rd_addr(set_idx),
		.rd_row (rd_row),
		.wr_en  (in_lookup),
		.wr_addr(set_s1),
		.wr_row (new_row)
	);

	sacl_lookup #(
		.NUM_WAYS(NUM_WAYS)
	) u_lookup (
		.row_in    (rd_row),
		.tag       (tag_s1),
		.is_write  (wr_s1),
		.write_back(cfg.write_back),
		.nw        (nw),
		.row_out   (new_row),
		.flags     (flags)
	);

	// Result strobe and running totals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= 1'b0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			fetch_cnt_q <= '0;
			memw_cnt_q  <= '0;
		end else begin
			done_q <= in_lookup;
			if (in_lookup) begin
				if (flags.hit) begin
					hit_cnt_q <= sat_inc(hit_cnt_q);
				end else begin
					miss_cnt_q  <= sat_inc(miss_cnt_q);
					fetch_cnt_q <= sat_inc(fetch_cnt_q);
				end
				if (flags.memw) begin
					memw_cnt_q <= sat_inc(memw_cnt_q);
				end
			end
		end
	end

	// Per-access flags of the result.
	always_ff @(posedge clk) begin
		if (in_lookup) begin
			hit_q   <= flags.hit;
			fetch_q <= flags.fetched;
			memw_q  <= flags.memw;
		end
	end

	assign done           = done_q;
	assign hit            = hit_q;
	assign fetched_block  = fetch_q;
	assign wrote_memory   = memw_q;
	assign hit_total      = hit_cnt_q;
	assign miss_total     = miss_cnt_q;
	assign fetch_total    = fetch_cnt_q;
	assign memwrite_total = memw_cnt_q;

endmodule

// ----- src/sacl_cfg.sv -----
// APB configuration registers of the cache model.
module sacl_cfg import sacl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output cfg_t        cfg
);

	cfg_t     cfg_q;
	reg_idx_t ridx;

	assign ridx = reg_idx_t'(paddr[3:2]);
	assign cfg  = cfg_q;

	// Register write on the access phase of a write transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_bits <= RST_OFFSET_BITS;
			cfg_q.index_bits  <= RST_INDEX_BITS;
			cfg_q.ways_in_use <= RST_WAYS;
			cfg_q.write_back  <= RST_WRITE_BACK;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_OFFSET_BITS: cfg_q.offset_bits <= pwdata[4:0];
				REG_INDEX_BITS:  cfg_q.index_bits  <= pwdata[3:0];
				REG_WAYS:        cfg_q.ways_in_use <= pwdata[3:0];
				REG_WRITE_BACK:  cfg_q.write_back  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read data mux.
	always_comb begin
		case (ridx)
			REG_OFFSET_BITS: prdata = {27'd0, cfg_q.offset_bits};
			REG_INDEX_BITS:  prdata = {28'd0, cfg_q.index_bits};
			REG_WAYS:        prdata = {28'd0, cfg_q.ways_in_use};
			REG_WRITE_BACK:  prdata = {31'd0, cfg_q.write_back};
			default:         prdata = 32'd0;
		endcase
	end

endmodule

// ----- src/sacl_set_mem.sv -----
// Set memory: one row per set holding tag, valid, dirty and age of every way.
module sacl_set_mem import sacl_pkg::*; #(
	parameter int NUM_SETS = DEF_NUM_SETS,
	parameter int NUM_WAYS = DEF_NUM_WAYS,
	localparam int SW     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1,
	localparam int AW     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1,
	localparam int LINE_W = TAG_W + 2 + AW,
	localparam int ROW_W  = NUM_WAYS * LINE_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [SW-1:0]    rd_addr,
	output logic [ROW_W-1:0] rd_row,
	input  logic             wr_en,
	input  logic [SW-1:0]    wr_addr,
	input  logic [ROW_W-1:0] wr_row
);

	logic [ROW_W-1:0]    mem_q [NUM_SETS];
	logic [NUM_SETS-1:0] written_q;
	logic [ROW_W-1:0]    rd_data_q;
	logic                rd_written_q;
	logic [ROW_W-1:0]    reset_row;

	// Storage array, synchronous write and registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_row;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Row written flags; an unwritten row reads as its reset contents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= written_q[rd_addr];
			end
		end
	end

	// Reset row: invalid, clean, age equal to the way number.
	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++) begin
			reset_row[w*LINE_W +: LINE_W] = {{TAG_W{1'b0}}, 2'b00, AW'(w)};
		end
	end

	assign rd_row = rd_written_q ? rd_data_q : reset_row;

endmodule

// ----- src/sacl_lookup.sv -----
// Tag compare, victim choice and LRU age update for one set row.
module sacl_lookup import sacl_pkg::*; #(
	parameter int NUM_WAYS = DEF_NUM_WAYS,
	localparam int AW     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1,
	localparam int NW_W   = $clog2(NUM_WAYS + 1),
	localparam int LINE_W = TAG_W + 2 + AW,
	localparam int ROW_W  = NUM_WAYS * LINE_W
) (
	input  logic [ROW_W-1:0] row_in,
	input  logic [TAG_W-1:0] tag,
	input  logic             is_write,
	input  logic             write_back,
	input  logic [NW_W-1:0]  nw,
	output logic [ROW_W-1:0] row_out,
	output acc_flags_t       flags
);

	logic [TAG_W-1:0] tg  [NUM_WAYS];
	logic             vld [NUM_WAYS];
	logic             drt [NUM_WAYS];
	logic [AW-1:0]    age [NUM_WAYS];
	logic             hit, hit_found, inv_found;
	logic [AW-1:0]    hit_way, inv_way, lru_way, way;
	logic [AW-1:0]    old_age, top_age;

	// Unpack the row.
	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++) begin
			{tg[w], vld[w], drt[w], age[w]} = row_in[w*LINE_W +: LINE_W];
		end
	end

	// Lowest matching way, first invalid way, and oldest way among those in use.
	always_comb begin
		hit_found = 1'b0;
		inv_found = 1'b0;
		hit_way   = '0;
		inv_way   = '0;
		lru_way   = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (NW_W'(w) < nw) begin
				if (!hit_found && vld[w] && tg[w] == tag) begin
					hit_found = 1'b1;
					hit_way   = AW'(w);
				end
				if (!inv_found && !vld[w]) begin
					inv_found = 1'b1;
					inv_way   = AW'(w);
				end
				if (age[w] < age[lru_way]) begin
					lru_way = AW'(w);
				end
			end
		end
		hit = hit_found;
		way = hit ? hit_way : (inv_found ? inv_way : lru_way);
	end

	assign old_age = age[way];
	assign top_age = AW'(nw - 1'b1);

	// Build the new row and the access flags.
	always_comb begin
		row_out = row_in;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (NW_W'(w) < nw && AW'(w) != way && age[w] > old_age && age[w] != '0) begin
				row_out[w*LINE_W +: AW] = age[w] - 1'b1;
			end
		end
		if (hit) begin
			row_out[way*LINE_W +: LINE_W] =
				{tg[way], 1'b1, drt[way] | (is_write & write_back), top_age};
		end else begin
			row_out[way*LINE_W +: LINE_W] =
				{tag, 1'b1, is_write & write_back, top_age};
		end
		flags.hit     = hit;
		flags.fetched = !hit;
		flags.memw    = (is_write && !write_back) || (!hit && vld[way] && drt[way]);
	end

endmodule

// ----- src/sacl_checker.sv -----
// Port-level checker for the cache model, bound to the top level.
module sacl_checker import sacl_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input logic             hit,
	input logic             fetched_block,
	input logic [CNT_W-1:0] hit_total,
	input logic [CNT_W-1:0] miss_total
);

	// An accepted transfer makes the block busy for one cycle only.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accept");

	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (!busy && done))
		else $error("result not delivered after busy cycle");

	// Every result is either a hit or a fetch, never both.
	a_hit_xor_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hit != fetched_block))
		else $error("hit and fetch flags disagree");

	// Totals move only with a result.
	a_totals_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!done |=> ($stable(hit_total) && $stable(miss_total)) || done)
		else $error("totals changed without a result");

endmodule

bind set_assoc_cache_lru_simulator_core sacl_checker u_sacl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.hit          (hit),
	.fetched_block(fetched_block),
	.hit_total    (hit_total),
	.miss_total   (miss_total)
);

// ----- tb/sv/set_assoc_cache_lru_simulator_core_tb.sv -----
// Self-checking testbench for the set-associative LRU cache tag model.
`timescale 1ns / 1ps

module set_assoc_cache_lru_simulator_core_tb;
	import sacl_pkg::*;

	localparam int SETS = DEF_NUM_SETS;
	localparam int WAYS = DEF_NUM_WAYS;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic             hit;
		logic             fetched;
		logic             memw;
		logic [CNT_W-1:0] hits;
		logic [CNT_W-1:0] misses;
		logic [CNT_W-1:0] fetches;
		logic [CNT_W-1:0] memwrites;
	} access_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic action = 1'b0;
	logic [ADDR_W-1:0] address = '0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic busy, done, hit, fetched_block, wrote_memory, pready;
	logic [CNT_W-1:0] hit_total, miss_total, fetch_total, memwrite_total;
	logic [31:0] prdata;

	// Shadow copy of the cache state and configuration.
	logic [TAG_W-1:0] tag_mem [SETS*WAYS];
	logic             valid_mem [SETS*WAYS];
	logic             dirty_mem [SETS*WAYS];
	logic [2:0]       age_mem [SETS*WAYS];
	logic [CNT_W-1:0] hits_cnt, misses_cnt, fetches_cnt, memwrites_cnt;
	logic [4:0]       cfg_offset;
	logic [3:0]       cfg_index;
	logic [3:0]       cfg_ways;
	logic             cfg_wb;

	access_result_t pending_results[$];
	int  error_count = 0;
	int  idle_cycles = 0;
	bit  allow_gaps = 1'b1;

	set_assoc_cache_lru_simulator_core uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.address(address), .done(done), .hit(hit), .fetched_block(fetched_block),
		.wrote_memory(wrote_memory), .hit_total(hit_total), .miss_total(miss_total),
		.fetch_total(fetch_total), .memwrite_total(memwrite_total), .psel(psel),
		.penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Predict the outcome of one access and update the shadow state.
	function automatic access_result_t predict_access(input logic wr, input logic [31:0] a);
		access_result_t r;
		int ib, nw, set_i, base, way, w, found;
		logic [63:0] blk;
		logic [31:0] tg;
		logic [2:0] old_age;
		ib = 0;
		while (ib < cfg_index && (1 << (ib + 1)) <= SETS) ib++;
		nw = (cfg_ways == 0) ? 1 : (cfg_ways > WAYS) ? WAYS : cfg_ways;
		blk = {32'd0, a} >> cfg_offset;
		set_i = int'(blk & ((64'd1 << ib) - 1)) % SETS;
		tg = 32'(blk >> ib);
		base = set_i * WAYS;
		r = '0;
		way = 0;
		for (w = 0; w < nw; w++) begin
			if (!r.hit && valid_mem[base+w] && tag_mem[base+w] == tg) begin
				r.hit = 1'b1;
				way = w;
			end
		end
		if (r.hit) begin
			hits_cnt = bump(hits_cnt);
			if (wr) begin
				if (cfg_wb) dirty_mem[base+way] = 1'b1;
				else r.memw = 1'b1;
			end
		end else begin
			misses_cnt = bump(misses_cnt);
			r.fetched = 1'b1;
			found = 0;
			for (w = 0; w < nw; w++) begin
				if (!found && !valid_mem[base+w]) begin
					way = w;
					found = 1;
				end
			end
			if (!found) begin
				way = 0;
				for (w = 1; w < nw; w++)
					if (age_mem[base+w] < age_mem[base+way]) way = w;
			end
			if (valid_mem[base+way] && dirty_mem[base+way]) r.memw = 1'b1;
			if (wr && !cfg_wb) r.memw = 1'b1;
			valid_mem[base+way] = 1'b1;
			tag_mem[base+way] = tg;
			dirty_mem[base+way] = wr && cfg_wb;
		end
		// LRU aging: ways used more recently than the touched one step down.
		old_age = age_mem[base+way];
		for (w = 0; w < nw; w++)
			if (w != way && age_mem[base+w] > old_age && age_mem[base+w] > 0)
				age_mem[base+w] = age_mem[base+w] - 1'b1;
		age_mem[base+way] = 3'(nw - 1);
		if (r.fetched) fetches_cnt = bump(fetches_cnt);
		if (r.memw) memwrites_cnt = bump(memwrites_cnt);
		r.hits = hits_cnt;
		r.misses = misses_cnt;
		r.fetches = fetches_cnt;
		r.memwrites = memwrites_cnt;
		return r;
	endfunction

	// Optional idle burst; start is dropped for its length.
	task automatic gap_cycles();
		int n;
		if (allow_gaps && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 10);
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Send one access and record its expected outcome at the transfer.
	task automatic send_access(input logic wr, input logic [31:0] a);
		gap_cycles();
		start <= 1'b1;
		action <= wr;
		address <= a;
		do @(posedge clk); while (busy);
		pending_results.insert(pending_results.size(), predict_access(wr, a));
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB register write; only issued while the block is idle.
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_OFFSET_BITS: cfg_offset = val[4:0];
			REG_INDEX_BITS:  cfg_index = val[3:0];
			REG_WAYS:        cfg_ways = val[3:0];
			REG_WRITE_BACK:  cfg_wb = val[0];
			default: ;
		endcase
	endtask

	task automatic configure(input int ob, input int ib, input int nw, input int wb);
		drain();
		write_reg(REG_OFFSET_BITS, ob);
		write_reg(REG_INDEX_BITS, ib);
		write_reg(REG_WAYS, nw);
		write_reg(REG_WRITE_BACK, wb);
	endtask

	// Directed checks: defaults, policies, extremes and reconfiguration cases.
	task automatic test_directed();
		send_access(1'b0, 32'h0000_0000);
		send_access(1'b1, 32'h0000_0004);
		send_access(1'b0, 32'hFFFF_FFFF);
		send_access(1'b1, 32'h0000_0000);
		configure(0, 8, 8, 0);
		send_access(1'b1, 32'h0000_0000);
		send_access(1'b1, 32'h0000_0000);
		send_access(1'b0, 32'hFFFF_FFFF);
		configure(16, 0, 8, 1);
		for (int i = 0; i < 10; i++) send_access(1'b1, i << 16);
		send_access(1'b0, 32'h0001_0000);
		configure(31, 15, 0, 1);
		send_access(1'b1, 32'h8000_0000);
		send_access(1'b0, 32'h0000_0001);
		configure(2, 3, 15, 0);
		send_access(1'b0, 32'h0000_0010);
		send_access(1'b1, 32'h0000_0010);
	endtask

	// Random accesses over a small address pool so that hits and evictions occur.
	task automatic test_random(input int count);
		logic [31:0] pool [16];
		logic [31:0] a;
		for (int i = 0; i < 16; i++) pool[i] = $urandom();
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) < 7) a = pool[$urandom_range(0, 15)] ^ $urandom_range(0, 15);
			else a = $urandom();
			send_access(1'($urandom_range(0, 1)), a);
		end
	endtask

	task automatic test_configs();
		configure(4, 2, 4, 1);
		test_random(150);
		configure(0, 0, 1, 0);
		test_random(100);
		configure($urandom_range(0, 20), $urandom_range(0, 15), $urandom_range(0, 15),
			$urandom_range(0, 1));
		test_random(150);
		configure(6, 1, 8, 1);
		test_random(150);
		configure(3, 0, 8, 0);
		test_random(100);
		// Last stretch runs back to back.
		allow_gaps = 1'b0;
		configure(4, 1, 3, 1);
		test_random(100);
	endtask

	// Compare each strobed result with the oldest expectation.
	always @(posedge clk) begin
		access_result_t e;
		if (done) begin
			if (pending_results.size() == 0) begin
				$error("result with no expectation pending");
				error_count++;
			end else begin
				e = pending_results.pop_front();
				if (hit !== e.hit) begin
					$error("hit exp %0d got %0d", e.hit, hit); error_count++;
				end
				if (fetched_block !== e.fetched) begin
					$error("fetched_block exp %0d got %0d", e.fetched, fetched_block);
					error_count++;
				end
				if (wrote_memory !== e.memw) begin
					$error("wrote_memory exp %0d got %0d", e.memw, wrote_memory);
					error_count++;
				end
				if (hit_total !== e.hits) begin
					$error("hit_total exp %0d got %0d", e.hits, hit_total); error_count++;
				end
				if (miss_total !== e.misses) begin
					$error("miss_total exp %0d got %0d", e.misses, miss_total);
					error_count++;
				end
				if (fetch_total !== e.fetches) begin
					$error("fetch_total exp %0d got %0d", e.fetches, fetch_total);
					error_count++;
				end
				if (memwrite_total !== e.memwrites) begin
					$error("memwrite_total exp %0d got %0d", e.memwrites, memwrite_total);
					error_count++;
				end
			end
		end
	end

	// Watchdog on cycles with no transfer of any kind.
	always @(posedge clk) begin
		if (done || (start && !busy) || (psel && penable)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < SETS*WAYS; i++) begin
			tag_mem[i] = '0;
			valid_mem[i] = 1'b0;
			dirty_mem[i] = 1'b0;
			age_mem[i] = 3'(i % WAYS);
		end
		hits_cnt = '0; misses_cnt = '0; fetches_cnt = '0; memwrites_cnt = '0;
		cfg_offset = RST_OFFSET_BITS;
		cfg_index = RST_INDEX_BITS;
		cfg_ways = RST_WAYS;
		cfg_wb = RST_WRITE_BACK;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_configs();
		drain();
		if (error_count == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- files.f -----
src/sacl_pkg.sv
src/sacl_cfg.sv
src/sacl_set_mem.sv
src/sacl_lookup.sv
src/set_assoc_cache_lru_simulator_core.sv
src/sacl_checker.sv
tb/sv/set_assoc_cache_lru_simulator_core_tb.sv
